### rtl/core/assert_macros.svh
// Assertion helpers shared by the csv splitter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/csvfs_pkg.sv
package csvfs_pkg;

    localparam int unsigned FIELD_MAX_DEFAULT = 64;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] field_byte;
        logic       byte_valid;
        logic       last_of_field;
        logic       last_of_line;
        logic       truncated;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush;
        logic empty;
        logic last;
    } sts_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_TAB) || (c == CH_SEMI);
    endfunction

endpackage

### rtl/core/csvfs_datapath.sv
`include "assert_macros.svh"

module csvfs_datapath #(
    parameter int unsigned FIELD_MAX = csvfs_pkg::FIELD_MAX_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  csvfs_pkg::cmd_t cmd,
    input  csvfs_pkg::req_t req_item,
    output csvfs_pkg::sts_t sts,
    output csvfs_pkg::res_t res_item
);
    import csvfs_pkg::*;

    localparam int unsigned LEN_W = $clog2(FIELD_MAX + 1);
    localparam int unsigned IDX_W = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_MAX);

    logic [7:0] mem [FIELD_MAX];

    logic [LEN_W-1:0] stored_reg, stored_next;
    logic [LEN_W-1:0] kept_reg, kept_next;
    logic             iq_reg, iq_next;
    logic             qp_reg, qp_next;
    logic             ovf_reg, ovf_next;

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] rd_idx_reg;
    logic             eol_reg;
    logic             trunc_reg;
    logic             empty_reg;
    logic             last_reg;
    logic [7:0]       rd_data_reg;
    res_t             res_reg;

    logic [7:0]       c;
    logic             iq_eff;
    logic             handled;
    logic             do_put;
    logic             flush;
    logic             blank;
    logic             wr_en;
    logic [LEN_W-1:0] n_emit;

    assign c = req_item.data_byte;

    // Parse one item: quote tracking, delimiter detection, trim bookkeeping.
    always_comb
    begin
        iq_eff      = iq_reg;
        iq_next     = iq_reg;
        qp_next     = qp_reg;
        handled     = 1'b0;
        do_put      = 1'b0;
        flush       = 1'b0;
        if (req_item.req_type == REQ_EOL)
        begin
            iq_next = 1'b0;
            qp_next = 1'b0;
            flush   = 1'b1;
        end
        else
        begin
            if (qp_reg)
            begin
                qp_next = 1'b0;
                if (c == CH_QUOTE)
                begin
                    do_put  = 1'b1;
                    handled = 1'b1;
                end
                else
                begin
                    iq_eff  = 1'b0;
                    iq_next = 1'b0;
                end
            end
            if (!handled)
            begin
                if (c == CH_QUOTE)
                begin
                    if (iq_eff)
                        qp_next = 1'b1;
                    else
                        iq_next = 1'b1;
                end
                else if (!iq_eff && is_delim(c))
                    flush = 1'b1;
                else
                    do_put = 1'b1;
            end
        end

        blank  = is_blank(c);
        wr_en  = do_put && !((stored_reg == '0) && blank) && (stored_reg < LEN_MAX);
        n_emit = ovf_reg ? stored_reg : kept_reg;

        stored_next = stored_reg;
        kept_next   = kept_reg;
        ovf_next    = ovf_reg;
        if (flush)
        begin
            stored_next = '0;
            kept_next   = '0;
            ovf_next    = 1'b0;
        end
        else if (wr_en)
        begin
            stored_next = stored_reg + LEN_W'(1);
            if (!blank)
                kept_next = stored_reg + LEN_W'(1);
        end
        else if (do_put && !blank && (stored_reg >= LEN_MAX))
            ovf_next = 1'b1;
    end

    assign sts.flush = flush;
    assign sts.empty = (n_emit == '0);
    assign sts.last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            kept_reg   <= '0;
            iq_reg     <= 1'b0;
            qp_reg     <= 1'b0;
            ovf_reg    <= 1'b0;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            eol_reg    <= 1'b0;
            trunc_reg  <= 1'b0;
            empty_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                stored_reg <= stored_next;
                kept_reg   <= kept_next;
                iq_reg     <= iq_next;
                qp_reg     <= qp_next;
                ovf_reg    <= ovf_next;
                if (flush)
                begin
                    count_reg  <= n_emit;
                    rd_idx_reg <= '0;
                    eol_reg    <= (req_item.req_type == REQ_EOL);
                    trunc_reg  <= ovf_reg;
                    empty_reg  <= (n_emit == '0);
                    last_reg   <= (n_emit == '0);
                end
            end
            else if (cmd.rd)
            begin
                last_reg   <= ((rd_idx_reg + LEN_W'(1)) == count_reg);
                rd_idx_reg <= rd_idx_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            mem[stored_reg[IDX_W-1:0]] <= c;
        if (cmd.rd)
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_reg.field_byte    <= empty_reg ? 8'h00 : rd_data_reg;
            res_reg.byte_valid    <= !empty_reg;
            res_reg.last_of_field <= last_reg;
            res_reg.last_of_line  <= eol_reg;
            res_reg.truncated     <= trunc_reg;
        end
    end

    assign res_item = res_reg;

    `ASSERT_ALWAYS(a_kept_le_stored, clk, rst_n, kept_reg <= stored_reg, "kept length past stored length")
    `ASSERT_ALWAYS(a_stored_le_max, clk, rst_n, stored_reg <= LEN_MAX, "stored length past store size")
    `ASSERT_IMPLIES(a_pending_in_quotes, clk, rst_n, qp_reg, iq_reg, "pending quote outside quotes")

endmodule

### rtl/core/csvfs_ctrl.sv
`include "assert_macros.svh"

module csvfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            res_valid,
    input  logic            res_stall,
    input  csvfs_pkg::sts_t sts,
    output csvfs_pkg::cmd_t cmd
);
    import csvfs_pkg::*;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && sts.flush)
                    state_next = sts.empty ? ST_LOAD : ST_READ;
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (out_free)
                    state_next = sts.last ? ST_IDLE : ST_READ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            ST_READ:
                cmd.rd = 1'b1;
            ST_LOAD:
                cmd.load = out_free;
            default:
                req_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    `ASSERT_NEXT(a_flush_leaves_idle, clk, rst_n, cmd.accept && sts.flush, state_reg != ST_IDLE, "flush did not start replay")
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.load, !res_valid_reg || !res_stall, "output register overwritten")

endmodule

### rtl/core/csv_field_splitter.sv
// CSV field splitter.
// Request channel (req_valid, req_stall, req_item): one transfer carries either
// a character of the line or an end-of-line marker. Result channel (res_valid,
// res_stall, res_item): one transfer per character of a trimmed field, or one
// empty marker for a field with nothing left after trimming.
// A character that does not close a field is taken without a stall and
// produces nothing. A delimiter or end of line closes the field: the block
// then holds req_stall high and replays the stored characters, each by a
// store read and then a load of the output register; an empty marker needs
// only the load. The output register decouples the sides: new input is
// taken while the last result of a field still waits. If res_stall is held,
// replay holds at the load step and the pending result stays unchanged.
// Reset clears the quote state, lengths and the output valid; the field store
// is not cleared and needs no clearing pass.
module csv_field_splitter #(
    parameter int unsigned FIELD_MAX = csvfs_pkg::FIELD_MAX_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  csvfs_pkg::req_t req_item,
    output logic            res_valid,
    input  logic            res_stall,
    output csvfs_pkg::res_t res_item
);
    import csvfs_pkg::*;

    // Commands and status between the sequencer and the datapath.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: accepts items, walks the replay, owns the output valid.
    csvfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: quote tracking, field store, trim lengths and result register.
    csvfs_datapath #(
        .FIELD_MAX (FIELD_MAX)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_item (req_item),
        .sts      (sts),
        .res_item (res_item)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import csvfs_pkg::*;

    localparam int FIELD_MAX    = FIELD_MAX_DEFAULT;
    localparam int DIRECTED_N   = 25;
    localparam int RANDOM_N     = 145;
    localparam int LONG_HOLD    = 300;      // receiver hold-off for the fill-up test
    localparam int DRAIN_CYCLES = 20;       // quiet time after the last result
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_item;
    logic res_valid;
    logic res_stall;
    res_t res_item;

    csv_field_splitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // One directed transfer; want holds a hand-written result for rows whose
    // single output is obvious, the rest go through the field predictor.
    typedef struct {
        req_t item;
        bit   typed;
        res_t want;
    } row_t;

    // Shadow of the splitter: field buffer, lengths and quote tracking.
    logic [7:0] fld_buf [FIELD_MAX];
    int         fld_len;
    int         fld_kept;
    bit         fld_cut;
    bit         quoted;
    bit         quote_held;

    res_t field_bytes_due[$];   // characters and empty markers still to arrive

    int  send_idle_pct;
    int  recv_idle_pct;
    int  items_sent;
    int  results_seen;
    int  lines_closed;
    int  empty_fields;
    int  cut_fields;
    int  mismatches;
    int  cycles;
    int  hold_left;
    logic hold_req;

    // 20 ns clock: high half, then low half.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Global watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     field_bytes_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic res_t res(logic [7:0] b, logic v, logic lof, logic lol, logic tr);
        res_t r;
        r.field_byte    = b;
        r.byte_valid    = v;
        r.last_of_field = lof;
        r.last_of_line  = lol;
        r.truncated     = tr;
        return r;
    endfunction

    function automatic req_t data_req(logic [7:0] c);
        req_t r;
        r.req_type  = REQ_DATA;
        r.data_byte = c;
        return r;
    endfunction

    function automatic req_t eol_req(logic [7:0] c);
        req_t r;
        r.req_type  = REQ_EOL;
        r.data_byte = c;
        return r;
    endfunction

    function automatic row_t mk(req_t it, bit typed, res_t want);
        row_t r;
        r.item  = it;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Whitespace set: space plus TAB through CR.
    function automatic bit blank_ch(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Append one character; drop leading blanks, flag overflow on non-blanks.
    function automatic void store_char(logic [7:0] c);
        bit b;
        b = blank_ch(c);
        if (fld_len == 0 && b)
            return;
        if (fld_len >= FIELD_MAX)
        begin
            if (!b)
                fld_cut = 1'b1;
            return;
        end
        fld_buf[fld_len] = c;
        fld_len++;
        if (!b)
            fld_kept = fld_len;
    endfunction

    // Emit the trimmed field (or one empty marker) and clear the buffer.
    function automatic void close_field(bit eol, ref res_t outs[$]);
        int n;
        n = fld_cut ? fld_len : fld_kept;
        if (n == 0)
            outs = {outs, res(8'h00, 1'b0, 1'b1, eol, fld_cut)};
        else
            for (int k = 0; k < n; k++)
                outs = {outs, res(fld_buf[k], 1'b1, k == n - 1, eol, fld_cut)};
        fld_len  = 0;
        fld_kept = 0;
        fld_cut  = 1'b0;
    endfunction

    // Predict the results of one accepted transfer.
    function automatic void split_item(req_t it, ref res_t outs[$]);
        logic [7:0] c;
        c = it.data_byte;
        if (it.req_type == REQ_EOL)
        begin
            quote_held = 1'b0;
            quoted     = 1'b0;
            close_field(1'b1, outs);
            return;
        end
        if (quote_held)
        begin
            quote_held = 1'b0;
            if (c == CH_QUOTE)
            begin
                store_char(CH_QUOTE);
                return;
            end
            quoted = 1'b0;
        end
        if (c == CH_QUOTE)
        begin
            if (quoted)
                quote_held = 1'b1;
            else
                quoted = 1'b1;
            return;
        end
        if (!quoted && (c == CH_COMMA || c == CH_TAB || c == CH_SEMI))
        begin
            close_field(1'b0, outs);
            return;
        end
        store_char(c);
    endfunction

    // Offer one transfer starting at a falling edge; return at the falling edge
    // after it was taken. The prediction is made at the accepting edge.
    task automatic offer(req_t it, bit typed, res_t want);
        res_t got[$];
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        split_item(it, got);
        if (typed)
            field_bytes_due = {field_bytes_due, want};
        else
            foreach (got[i])
                field_bytes_due = {field_bytes_due, got[i]};
        if (it.req_type == REQ_EOL)
            lines_closed++;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send(req_t it);
        offer(it, 1'b0, res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    function automatic logic [7:0] any_delim();
        case ($urandom_range(2))
            0:       return CH_COMMA;
            1:       return CH_SEMI;
            default: return CH_TAB;
        endcase
    endfunction

    // Blanks that are not also delimiters outside quotes.
    function automatic logic [7:0] pad_char();
        case ($urandom_range(4))
            0:       return 8'h0A;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // Field content outside quotes: mostly printable, some interior blanks,
    // some high bytes.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        case ($urandom_range(9))
            0:       return 8'h80 + 8'($urandom_range(127));
            1:       return CH_SPACE;
            default:
            begin
                do
                    c = 8'($urandom_range(32, 126));
                while (c == CH_QUOTE || c == CH_COMMA || c == CH_SEMI);
                return c;
            end
        endcase
    endfunction

    // Send one field body with padding; quoted bodies carry delimiters and
    // doubled quotes.
    task automatic send_field(bit quote_it, int body_len, int lead, int trail);
        repeat (lead)
            send(data_req(pad_char()));
        if (quote_it)
            send(data_req(CH_QUOTE));
        for (int i = 0; i < body_len; i++)
        begin
            if (quote_it && $urandom_range(7) == 0)
                send(data_req(any_delim()));
            else if (quote_it && $urandom_range(7) == 0)
            begin
                send(data_req(CH_QUOTE));
                send(data_req(CH_QUOTE));
            end
            else
                send(data_req(plain_char()));
        end
        if (quote_it)
            send(data_req(CH_QUOTE));
        repeat (trail)
            send(data_req(pad_char()));
    endtask

    // One random line, or now and then a burst of raw noise.
    task automatic send_line();
        int nf;
        int len;
        if ($urandom_range(7) == 0)
        begin
            repeat ($urandom_range(3, 10))
                if ($urandom_range(5) == 0)
                    send(eol_req(8'($urandom_range(255))));
                else
                    send(data_req(8'($urandom_range(255))));
            return;
        end
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++)
        begin
            len = ($urandom_range(24) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
            send_field($urandom_range(2) == 0, len, $urandom_range(2), $urandom_range(2));
            if (f < nf - 1)
                send(data_req(any_delim()));
            else
                send(eol_req(8'($urandom_range(255))));
        end
    endtask

    // Receiver: random stall, or a long counted hold-off on request.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req)
        begin
            res_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_req  <= 1'b0;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker: every transfer must match the oldest pending result.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (field_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected result byte=%02h valid=%0b lof=%0b lol=%0b tr=%0b",
                         $time, res_item.field_byte, res_item.byte_valid,
                         res_item.last_of_field, res_item.last_of_line, res_item.truncated);
                mismatches++;
            end
            else
            begin
                if (res_item !== field_bytes_due[0])
                begin
                    $display("%0t: expected byte=%02h valid=%0b lof=%0b lol=%0b tr=%0b",
                             $time, field_bytes_due[0].field_byte,
                             field_bytes_due[0].byte_valid, field_bytes_due[0].last_of_field,
                             field_bytes_due[0].last_of_line, field_bytes_due[0].truncated);
                    $display("%0t: actual   byte=%02h valid=%0b lof=%0b lol=%0b tr=%0b",
                             $time, res_item.field_byte, res_item.byte_valid,
                             res_item.last_of_field, res_item.last_of_line,
                             res_item.truncated);
                    mismatches++;
                end
                if (field_bytes_due[0].last_of_field && field_bytes_due[0].truncated)
                    cut_fields++;
                if (!field_bytes_due[0].byte_valid)
                    empty_fields++;
                void'(field_bytes_due.pop_front());
                results_seen++;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        int   fill_items;

        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_item      = '0;
        res_stall     = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        cycles        = 0;
        items_sent    = 0;
        results_seen  = 0;
        lines_closed  = 0;
        empty_fields  = 0;
        cut_fields    = 0;
        mismatches    = 0;
        fld_len       = 0;
        fld_kept      = 0;
        fld_cut       = 1'b0;
        quoted        = 1'b0;
        quote_held    = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 81;
        fill_items    = 0;

        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty line and empty field, a one-character field,
        // quoted blank dropped as leading space, doubled quote, pending quote
        // closed by a plain byte, delimiter inside quotes, pending quote at end
        // of line, unclosed quotes at end of line, ignored byte on end of line,
        // trailing and leading blanks trimmed.
        rows = {rows, mk(eol_req(8'h00), 1, res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0))};
        rows = {rows, mk(data_req(CH_COMMA), 1, res(8'h00, 1'b0, 1'b1, 1'b0, 1'b0))};
        rows = {rows, mk(data_req(8'h61), 0, '0)};
        rows = {rows, mk(data_req(CH_SEMI), 1, res(8'h61, 1'b1, 1'b1, 1'b0, 1'b0))};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(CH_SPACE), 0, '0)};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(8'hFF), 0, '0)};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(8'h00), 0, '0)};
        rows = {rows, mk(data_req(CH_TAB), 0, '0)};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(CH_COMMA), 0, '0)};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(eol_req(8'h00), 1, res(CH_COMMA, 1'b1, 1'b1, 1'b1, 1'b0))};
        rows = {rows, mk(data_req(CH_QUOTE), 0, '0)};
        rows = {rows, mk(data_req(8'h78), 0, '0)};
        rows = {rows, mk(eol_req(8'h00), 1, res(8'h78, 1'b1, 1'b1, 1'b1, 1'b0))};
        rows = {rows, mk(data_req(CH_COMMA), 1, res(8'h00, 1'b0, 1'b1, 1'b0, 1'b0))};
        rows = {rows, mk(eol_req(8'hFF), 1, res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0))};
        rows = {rows, mk(data_req(CH_CR), 0, '0)};
        rows = {rows, mk(data_req(8'h7F), 0, '0)};
        rows = {rows, mk(data_req(CH_SPACE), 0, '0)};
        rows = {rows, mk(eol_req(8'h00), 1, res(8'h7F, 1'b1, 1'b1, 1'b1, 1'b0))};
        foreach (rows[i])
            offer(rows[i].item, rows[i].typed, rows[i].want);

        // Random lines: sender mostly active, receiver mostly stalled.
        while (items_sent < DIRECTED_N + RANDOM_N / 3)
            send_line();

        // Swap the pressure: sender mostly idle, receiver mostly ready.
        send_idle_pct = 81;
        recv_idle_pct = 26;
        while (items_sent < DIRECTED_N + 2 * RANDOM_N / 3)
            send_line();

        // Full rate. Hold the receiver off for a long stretch and keep
        // offering so the output register fills and req_stall rises.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fill_items    = items_sent;
        hold_req <= 1'b1;
        send_field(1'b0, 20, 0, 0);
        send(data_req(CH_COMMA));
        send_field(1'b0, 6, 1, 1);
        send(data_req(CH_SEMI));

        // Store-full cases: exactly full, full then blanks then a non-blank
        // (cut with trailing blanks kept), and a plain overlong field.
        send_field(1'b0, FIELD_MAX, 0, 2);
        send(data_req(CH_COMMA));
        for (int i = 0; i < FIELD_MAX; i++)
            send(data_req(8'h41 + 8'(i % 26)));
        repeat (3)
            send(data_req(CH_SPACE));
        send(data_req(8'h7A));
        send(data_req(CH_COMMA));
        send_field(1'b0, FIELD_MAX + 6, 1, 1);
        send(eol_req(8'h00));
        fill_items = items_sent - fill_items;

        while (items_sent < DIRECTED_N + RANDOM_N + fill_items)
            send_line();
        req_valid <= 1'b0;

        // Drain: wait for every predicted result, then let the block settle.
        while (field_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("%0d transfers in, %0d results out over %0d lines", items_sent,
                 results_seen, lines_closed);
        $display("%0d empty fields, %0d cut fields, %0d mismatches", empty_fields,
                 cut_fields, mismatches);
        if (mismatches == 0 && field_bytes_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
